// ===== design/htfp_pkg.sv =====
package htfp_pkg;

	localparam int CHARS_PER_WORD = 8;
	localparam int COUNT_W        = $clog2(CHARS_PER_WORD + 1);
	localparam int ADDR_W         = 24;
	localparam int WORD_W         = 32;
	localparam int NIB_W          = 4;
	localparam int CHAR_W         = 8;
	localparam int CMD_W          = 8;

	localparam logic [CMD_W-1:0]  CMD_PROGRAM_LONGWORD = 8'h06;
	localparam logic [CMD_W-1:0]  CMD_ERASE_SECTOR     = 8'h09;
	localparam logic              ACTION_ERASE         = 1'b1;
	localparam logic [ADDR_W-1:0] WORD_STRIDE          = 24'd4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
	localparam logic [CHAR_W-1:0] TEN          = 8'd10;

	typedef struct packed {
		logic [CMD_W-1:0]  command_code;
		logic [ADDR_W-1:0] flash_address;
		logic [WORD_W-1:0] data_word;
	} result_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} buf_status_t;

	typedef struct packed {
		logic             valid;
		logic [NIB_W-1:0] value;
	} nibble_t;

	// ascii hex digit decode, uppercase only
	function automatic nibble_t hex_value(input logic [CHAR_W-1:0] c);
		nibble_t      r;
		logic [CHAR_W-1:0] d;
		r = '0;
		d = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d       = c - CHAR_ZERO;
			r.valid = 1'b1;
			r.value = d[NIB_W-1:0];
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			d       = c - CHAR_UPPER_A + TEN;
			r.valid = 1'b1;
			r.value = d[NIB_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/htfp_packer.sv =====
module htfp_packer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         action,
	input  logic [htfp_pkg::CHAR_W-1:0]  char_code,
	input  logic                         last_char,
	input  logic [htfp_pkg::ADDR_W-1:0]  sector_address,
	input  logic [htfp_pkg::ADDR_W-1:0]  base_address,
	output logic                         produced,
	output htfp_pkg::result_t            result
);

	logic [htfp_pkg::COUNT_W-1:0]  count_q;
	logic [htfp_pkg::WORD_W-1:0]   acc_q;
	logic                          bad_q;
	logic [htfp_pkg::ADDR_W-1:0]   next_addr_q;
	logic                          in_transfer_q;

	htfp_pkg::nibble_t             nib;
	logic [htfp_pkg::COUNT_W-1:0]  count_new;
	logic [htfp_pkg::COUNT_W-1:0]  pad_cnt;
	logic [htfp_pkg::COUNT_W+1:0]  pad_bits;
	logic [htfp_pkg::WORD_W-1:0]   acc_new;
	logic [htfp_pkg::WORD_W-1:0]   acc_out;
	logic                          word_full;
	logic                          word_done;
	logic                          bad_new;
	logic [htfp_pkg::ADDR_W-1:0]   cur_addr;
	logic                          is_erase;

	always_comb begin
		is_erase  = (action == htfp_pkg::ACTION_ERASE);
		nib       = htfp_pkg::hex_value(char_code);
		count_new = count_q + htfp_pkg::COUNT_W'(1);
		acc_new   = {acc_q[htfp_pkg::WORD_W-htfp_pkg::NIB_W-1:0],
			nib.valid ? nib.value : '0};
		word_full = (count_new == htfp_pkg::COUNT_W'(htfp_pkg::CHARS_PER_WORD));
		word_done = word_full || last_char;
		// pad a short final word with zero nibbles
		pad_cnt   = htfp_pkg::COUNT_W'(htfp_pkg::CHARS_PER_WORD) - count_new;
		pad_bits  = {pad_cnt, 2'b00};
		acc_out   = last_char ? (acc_new << pad_bits) : acc_new;
		bad_new   = bad_q || !nib.valid;
		cur_addr  = in_transfer_q ? next_addr_q : base_address;

		if (is_erase) begin
			produced             = 1'b1;
			result.command_code  = htfp_pkg::CMD_ERASE_SECTOR;
			result.flash_address = sector_address;
			result.data_word     = '0;
		end else begin
			produced             = word_done && !bad_new;
			result.command_code  = htfp_pkg::CMD_PROGRAM_LONGWORD;
			result.flash_address = cur_addr;
			result.data_word     = acc_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			acc_q         <= '0;
			bad_q         <= 1'b0;
			next_addr_q   <= '0;
			in_transfer_q <= 1'b0;
		end else if (accept && !is_erase) begin
			if (last_char) begin
				count_q       <= '0;
				acc_q         <= '0;
				bad_q         <= 1'b0;
				next_addr_q   <= base_address;
				in_transfer_q <= 1'b0;
			end else if (word_done) begin
				count_q       <= '0;
				acc_q         <= '0;
				bad_q         <= 1'b0;
				next_addr_q   <= bad_new ? cur_addr : cur_addr + htfp_pkg::WORD_STRIDE;
				in_transfer_q <= 1'b1;
			end else begin
				count_q       <= count_new;
				acc_q         <= acc_new;
				bad_q         <= bad_new;
				next_addr_q   <= cur_addr;
				in_transfer_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/htfp_out_buf.sv =====
module htfp_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  htfp_pkg::result_t     push_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output htfp_pkg::result_t     out_data,
	output htfp_pkg::buf_status_t status
);

	logic              main_valid_q;
	logic              skid_valid_q;
	htfp_pkg::result_t main_q;
	htfp_pkg::result_t skid_q;
	logic              pop;

	assign pop               = main_valid_q && !out_stall;
	assign out_valid         = main_valid_q;
	assign out_data          = main_q;
	assign status.main_valid = main_valid_q;
	assign status.skid_valid = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== design/hex_text_flash_programmer.sv =====
// ascii hex text to flash command packer
// input channel: in_valid / in_stall with one character word per handshake
//   (action, char_code, last_char, sector_address)
// output channel: out_valid / out_stall with one flash command word
//   (command_code, flash_address, data_word)
// cfg_write / cfg_data load the 24-bit base address; the new value is used
//   from the next transfer on
// eight uppercase hex characters make one program-long-word command; a word
//   with any other character is dropped and the address does not move
// an erase action gives an erase-sector command right away and leaves the
//   packing state alone
// a command is registered in the output buffer, not passed through, before it
//   shows on the output
// throughput: one character per cycle while in_stall is low, set by the
//   packer and the two-entry output buffer
// reset clears the packer, the base address and the output buffer
// when the receiver stalls, one more command is held in the skid entry;
//   in_stall rises only while that entry is full
module hex_text_flash_programmer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [htfp_pkg::CHAR_W-1:0]         char_code,
	input  logic                                last_char,
	input  logic [htfp_pkg::ADDR_W-1:0]         sector_address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [htfp_pkg::CMD_W-1:0]          command_code,
	output logic [htfp_pkg::ADDR_W-1:0]         flash_address,
	output logic [htfp_pkg::WORD_W-1:0]         data_word,
	input  logic                                cfg_write,
	input  logic [htfp_pkg::ADDR_W-1:0]         cfg_data
);

	logic [htfp_pkg::ADDR_W-1:0] base_q;
	logic                        accept;
	logic                        produced;
	htfp_pkg::result_t           result;
	htfp_pkg::result_t           out_data;
	htfp_pkg::buf_status_t       buf_status;

	// base address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_write) begin
			base_q <= cfg_data;
		end
	end

	// stall only when the skid entry already holds a command
	assign in_stall = buf_status.skid_valid;
	assign accept   = in_valid && !in_stall;

	htfp_packer u_packer (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.action         (action),
		.char_code      (char_code),
		.last_char      (last_char),
		.sector_address (sector_address),
		.base_address   (base_q),
		.produced       (produced),
		.result         (result)
	);

	htfp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && produced),
		.push_data (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (buf_status)
	);

	assign command_code  = out_data.command_code;
	assign flash_address = out_data.flash_address;
	assign data_word     = out_data.data_word;

	// skid entry is only ever filled behind a valid main entry
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		buf_status.skid_valid |-> buf_status.main_valid)
		else $error("skid entry valid with empty output register");

	// an erase taken into an empty buffer shows up next cycle
	a_erase_next_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == htfp_pkg::ACTION_ERASE && !out_valid) |=>
		(out_valid && command_code == htfp_pkg::CMD_ERASE_SECTOR))
		else $error("erase command not presented one cycle after accept");

	// a drained buffer with no new word goes empty
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !buf_status.skid_valid && !in_valid) |=> !out_valid)
		else $error("output valid without a pending command");

endmodule

// ===== tb/htfp_tb_pkg.sv =====
package htfp_tb_pkg;

	import htfp_pkg::*;

	class htfp_scoreboard;
		logic [ADDR_W-1:0] base_addr;
		logic [ADDR_W-1:0] next_addr;
		logic [WORD_W-1:0] packed_word;
		int unsigned       nibbles;
		bit                bad_word;
		bit                in_xfer;
		result_t           cmd_q[$];
		int                errors;

		function new();
			base_addr = '0;
			clear_word();
			next_addr = '0;
			in_xfer   = 1'b0;
			errors    = 0;
		endfunction

		function void clear_word();
			nibbles     = 0;
			packed_word = '0;
			bad_word    = 1'b0;
		endfunction

		function void set_base(logic [ADDR_W-1:0] v);
			base_addr = v;
		endfunction

		function int pending();
			return cmd_q.size();
		endfunction

		// uppercase hex digit to nibble, returns 0 for anything else
		function bit digit_of(logic [CHAR_W-1:0] c, output logic [NIB_W-1:0] n);
			logic [CHAR_W-1:0] d;
			n = '0;
			d = '0;
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = c - CHAR_ZERO;
				n = d[NIB_W-1:0];
				return 1'b1;
			end
			if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
				d = c - CHAR_UPPER_A + TEN;
				n = d[NIB_W-1:0];
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// predict the command, if any, that one accepted character word causes
		function void note_word(logic act, logic [CHAR_W-1:0] c, logic last,
				logic [ADDR_W-1:0] sector);
			result_t          r;
			logic [NIB_W-1:0] n;
			if (act == ACTION_ERASE) begin
				r.command_code  = CMD_ERASE_SECTOR;
				r.flash_address = sector;
				r.data_word     = '0;
				cmd_q.push_back(r);
				return;
			end
			if (!in_xfer) begin
				next_addr = base_addr;
				in_xfer   = 1'b1;
			end
			if (!digit_of(c, n))
				bad_word = 1'b1;
			packed_word = {packed_word[WORD_W-NIB_W-1:0], n};
			nibbles++;
			if (last) begin
				while (nibbles < CHARS_PER_WORD) begin
					packed_word = packed_word << NIB_W;
					nibbles++;
				end
			end
			if (nibbles >= CHARS_PER_WORD) begin
				if (!bad_word) begin
					r.command_code  = CMD_PROGRAM_LONGWORD;
					r.flash_address = next_addr;
					r.data_word     = packed_word;
					cmd_q.push_back(r);
					next_addr = next_addr + WORD_STRIDE;
				end
				clear_word();
			end
			if (last) begin
				clear_word();
				next_addr = base_addr;
				in_xfer   = 1'b0;
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (cmd_q.size() == 0) begin
				report($sformatf("unexpected command %h addr %h data %h",
					got.command_code, got.flash_address, got.data_word));
				return;
			end
			want = cmd_q.pop_front();
			if (got.command_code !== want.command_code)
				report($sformatf("command_code got %h want %h",
					got.command_code, want.command_code));
			if (got.flash_address !== want.flash_address)
				report($sformatf("flash_address got %h want %h",
					got.flash_address, want.flash_address));
			if (got.data_word !== want.data_word)
				report($sformatf("data_word got %h want %h",
					got.data_word, want.data_word));
		endtask
	endclass

endpackage

// ===== tb/hex_text_flash_programmer_tb.sv =====
module hex_text_flash_programmer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import htfp_pkg::*;
	import htfp_tb_pkg::*;

	// every input known from time zero
	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic              action         = 1'b0;
	logic [CHAR_W-1:0] char_code      = '0;
	logic              last_char      = 1'b0;
	logic [ADDR_W-1:0] sector_address = '0;
	logic              out_valid;
	logic              out_stall      = 1'b1;
	logic [CMD_W-1:0]  command_code;
	logic [ADDR_W-1:0] flash_address;
	logic [WORD_W-1:0] data_word;
	logic              cfg_write      = 1'b0;
	logic [ADDR_W-1:0] cfg_data       = '0;

	htfp_scoreboard sb = new();

	// per-phase switches that turn idling off on one side
	bit calm_tx = 1'b0;
	bit calm_rx = 1'b0;
	int chars_sent = 0;

	hex_text_flash_programmer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.char_code      (char_code),
		.last_char      (last_char),
		.sector_address (sector_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.command_code   (command_code),
		.flash_address  (flash_address),
		.data_word      (data_word),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop well past the slowest correct run
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// random idle gap before one word on either side; none when calm
	function automatic int draw_gap(bit calm);
		if (calm)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char();
		int unsigned v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CHAR_ZERO + CHAR_W'(v);
		return CHAR_UPPER_A + CHAR_W'(v - 10);
	endfunction

	// characters meant to spoil a word: lowercase, neighbors of the digit ranges,
	// 8'hFF or 8'h00, or any byte at all, which may still be a valid digit
	function automatic logic [CHAR_W-1:0] bad_char();
		logic [CHAR_W-1:0] c;
		case ($urandom_range(0, 3))
			0: begin
				c = 8'h61 + CHAR_W'($urandom_range(0, 5));
			end
			1: begin
				case ($urandom_range(0, 3))
					0: c = CHAR_ZERO - 8'd1;
					1: c = CHAR_NINE + 8'd1;
					2: c = CHAR_UPPER_A - 8'd1;
					default: c = CHAR_UPPER_F + 8'd1;
				endcase
			end
			2: begin
				c = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: begin
				c = CHAR_W'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	// offer one input word and hold it until it is taken
	task automatic send_word(logic act, logic [CHAR_W-1:0] c, logic last,
			logic [ADDR_W-1:0] sector);
		int gap;
		gap = draw_gap(calm_tx);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		action         <= act;
		char_code      <= c;
		last_char      <= last;
		sector_address <= sector;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(act, c, last, sector);
		chars_sent++;
	endtask

	task automatic send_text(string s, bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_word(1'b0, s[i], last_at_end && (i == s.len() - 1),
				ADDR_W'($urandom));
	endtask

	// stop offering and wait until every predicted command has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// base address write, only with the block idle; a character that gives
	// no command may still be inside, so it waits on after the drain first
	task automatic write_base(logic [ADDR_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_base(v);
	endtask

	// one transfer: mostly clean hex with a few spoiled characters and erases
	// mixed in, now and then pure noise or a transfer left open
	task automatic run_transfer();
		int len;
		bit noisy;
		bit open_end;
		logic [CHAR_W-1:0] c;
		noisy    = ($urandom_range(0, 9) == 0);
		open_end = ($urandom_range(0, 9) == 0);
		len      = $urandom_range(0, 4) * CHARS_PER_WORD + $urandom_range(0, 7);
		if (len == 0)
			len = 1;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(ACTION_ERASE, CHAR_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), ADDR_W'($urandom));
			if (noisy)
				c = CHAR_W'($urandom_range(0, 255));
			else if ($urandom_range(0, 29) == 0)
				c = bad_char();
			else
				c = hex_char();
			send_word(1'b0, c, !open_end && (i == len - 1), ADDR_W'($urandom));
			// now and then let the output side run completely dry
			if ($urandom_range(0, 49) == 0)
				wait_drained();
		end
	endtask

	// command receiver, stalls a random while before each command
	initial begin : receiver
		int      gap;
		result_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(calm_rx);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			got = {command_code, flash_address, data_word};
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] bases[6];
		int start;
		bases[0] = 24'hFFFFFF;
		bases[1] = 24'h000000;
		bases[2] = 24'hFFFFFC;
		bases[3] = ADDR_W'($urandom);
		bases[4] = 24'hFFFFF0;
		bases[5] = ADDR_W'($urandom);

		// reset held from time zero, released once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_base(24'h000100);

		// every digit, first word at the base address
		send_text("01234567", 1'b0);
		// erase inside a word leaves the packing alone; last on a word boundary
		send_word(1'b0, "8", 1'b0, 24'h000000);
		send_text("9AB", 1'b0);
		send_word(ACTION_ERASE, 8'h7A, 1'b1, 24'hFFFFFF);
		send_text("CDEF", 1'b1);
		// lowercase as the only, last character: padded then dropped
		send_word(1'b0, "c", 1'b1, 24'hFFFFFF);
		// single digit padded with zero nibbles, transfer restarts at base
		send_text("9", 1'b1);
		// byte extremes spoil a word
		send_word(1'b0, 8'hFF, 1'b0, 24'h000000);
		send_word(1'b0, 8'h00, 1'b1, 24'hFFFFFF);
		send_word(ACTION_ERASE, 8'h00, 1'b0, 24'h000000);

		// random phases over several base addresses, wraps included
		for (int p = 0; p < 6; p++) begin
			calm_tx = (p == 1) || (p == 3);
			calm_rx = (p == 2) || (p == 3);
			write_base(bases[p]);
			start = chars_sent;
			while (chars_sent - start < 316)
				run_transfer();
		end

		// let everything drain, then wait on for stray commands
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
